[hw/rtl/shapad_pkg.sv]
// Shared types and constants for the SHA-256 message padder.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package shapad_pkg;

   localparam int unsigned ByteW    = 8;
   localparam int unsigned WordW    = 32;
   localparam int unsigned IndexW   = 4;
   localparam int unsigned PosW     = 6;
   localparam int unsigned CountW   = 61;
   localparam int unsigned ResultsW = 5;
   localparam int unsigned DataW    = 40;  // word_out + word_index, padded to whole bytes

   localparam logic [ByteW-1:0]    PadMark      = 8'h80;
   localparam logic [ResultsW-1:0] MaxResults   = 5'd18;
   localparam logic [IndexW-1:0]   LastIndex    = 4'd15;
   // word index just before the two length words
   localparam logic [IndexW-1:0]   PreLenIndex  = 4'd13;

   // datapath operations
   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_HELD  = 3'd1;
   localparam logic [2:0] OP_BYTE  = 3'd2;
   localparam logic [2:0] OP_MARK  = 3'd3;
   localparam logic [2:0] OP_ZERO  = 3'd4;
   localparam logic [2:0] OP_LENHI = 3'd5;
   localparam logic [2:0] OP_LENLO = 3'd6;
   localparam logic [2:0] OP_HOLD  = 3'd7;

   typedef logic [2:0] op_type;

   typedef struct packed {
      logic   take_item;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic present;       // captured item carries a byte
      logic last;          // captured item ends the message
      logic word_full;     // next byte completes a word
      logic pre_len;       // current word is the one before the length words
      logic held;          // final length word of the previous message waits
      logic slot_free;     // result register can take a word this cycle
   } status_type;

endpackage

[hw/rtl/sha256_message_padder.sv]
// SHA-256 message padder: bytes in, padded 512-bit blocks out as 32-bit words.
// A plain byte transaction is captured, then shifted into the word accumulator
// once the result register has room. A transaction marked last then writes each
// padding or length word, up to 18, through the single result register, so the
// output side's ready sets the pace of that tail.
// When a last byte lands on byte 56 of a block, the final length word is
// delivered first during the next transaction. Depends on shapad_pkg,
// shapad_ctrl and shapad_dp.
`timescale 1ns / 1ps

module sha256_message_padder
   import shapad_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [ByteW-1:0] req_tdata,   // [7:0] data_byte
   input  logic             req_tuser,   // [0] byte_present
   input  logic             req_tlast,   // last_of_message
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [DataW-1:0] rsp_tdata,   // [31:0] word_out, [35:32] word_index, [39:36] zero
   output logic             rsp_tuser,   // [0] block_end
   output logic             rsp_tlast    // message_end
);

   cmd_type    cmd;
   status_type status;

   shapad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   shapad_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[hw/rtl/shapad_dp.sv]
// Datapath of the SHA-256 message padder: item capture, word accumulator,
// block position, byte count and the result register. Uses shapad_pkg.
`timescale 1ns / 1ps

module shapad_dp
   import shapad_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic [ByteW-1:0]        req_tdata,
   input  logic                    req_tuser,
   input  logic                    req_tlast,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [DataW-1:0]        rsp_tdata,
   output logic                    rsp_tuser,
   output logic                    rsp_tlast
);

   logic [ByteW-1:0]  byte_ff, byte_in;
   logic              present_ff, present_in;
   logic              last_ff, last_in;
   logic [WordW-1:0]  acc_ff, acc_in;
   logic [PosW-1:0]   pos_ff, pos_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              held_ff, held_in;

   logic              valid_ff, valid_in;
   logic [WordW-1:0]  word_ff, word_in;
   logic [IndexW-1:0] index_ff, index_in;
   logic              bend_ff, bend_in;
   logic              mend_ff, mend_in;

   logic              slot_free;
   logic [IndexW-1:0] cur_index;
   logic [PosW-1:0]   next_word_pos;
   logic [WordW-1:0]  shifted;
   logic [WordW-1:0]  marked;
   logic [4:0]        mark_shift;
   logic [WordW-1:0]  len_lo;

   assign slot_free     = !valid_ff || rsp_tready;
   assign cur_index     = pos_ff[PosW-1:2];
   assign next_word_pos = {cur_index + 4'd1, 2'b00};
   assign shifted       = {acc_ff[WordW-ByteW-1:0], byte_ff};
   // left-justify the partial word after the marker byte
   assign mark_shift    = {~pos_ff[1:0], 3'b000};
   assign marked        = {acc_ff[WordW-ByteW-1:0], PadMark} << mark_shift;
   assign len_lo        = {count_ff[WordW-4:0], 3'b000};

   always_comb begin
      byte_in    = byte_ff;
      present_in = present_ff;
      last_in    = last_ff;
      acc_in     = acc_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      held_in    = held_ff;
      valid_in   = valid_ff && !rsp_tready;
      word_in    = word_ff;
      index_in   = index_ff;
      bend_in    = bend_ff;
      mend_in    = mend_ff;

      if (cmd.take_item) begin
         byte_in    = req_tdata;
         present_in = req_tuser;
         last_in    = req_tlast;
      end

      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_HELD: begin
            valid_in = 1'b1;
            word_in  = len_lo;
            index_in = LastIndex;
            mend_in  = 1'b1;
            count_in = '0;
            held_in  = 1'b0;
         end
         OP_BYTE: begin
            if (present_ff) begin
               acc_in   = shifted;
               pos_in   = pos_ff + 6'd1;
               count_in = count_ff + 61'd1;
               if (pos_ff[1:0] == 2'b11) begin
                  valid_in = 1'b1;
                  word_in  = shifted;
                  index_in = cur_index;
                  mend_in  = 1'b0;
                  acc_in   = '0;
               end
            end
         end
         OP_MARK: begin
            valid_in = 1'b1;
            word_in  = marked;
            index_in = cur_index;
            mend_in  = 1'b0;
            acc_in   = '0;
            pos_in   = next_word_pos;
         end
         OP_ZERO: begin
            valid_in = 1'b1;
            word_in  = '0;
            index_in = cur_index;
            mend_in  = 1'b0;
            pos_in   = next_word_pos;
         end
         OP_LENHI: begin
            valid_in = 1'b1;
            word_in  = count_ff[CountW-1:CountW-WordW];
            index_in = cur_index;
            mend_in  = 1'b0;
            pos_in   = next_word_pos;
         end
         OP_LENLO: begin
            valid_in = 1'b1;
            word_in  = len_lo;
            index_in = cur_index;
            mend_in  = 1'b1;
            count_in = '0;
            pos_in   = '0;
            acc_in   = '0;
         end
         OP_HOLD: begin
            // keep the count: the final word is rebuilt from it later
            held_in = 1'b1;
            pos_in  = '0;
            acc_in  = '0;
         end
         default: begin
         end
      endcase

      bend_in = (index_in == LastIndex);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         pos_ff   <= '0;
         count_ff <= '0;
         held_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
         held_ff  <= held_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      present_ff <= present_in;
      last_ff    <= last_in;
      word_ff    <= word_in;
      index_ff   <= index_in;
      bend_ff    <= bend_in;
      mend_ff    <= mend_in;
   end

   assign status.present   = present_ff;
   assign status.last      = last_ff;
   assign status.word_full = (pos_ff[1:0] == 2'b11);
   assign status.pre_len   = (cur_index == PreLenIndex);
   assign status.held      = held_ff;
   assign status.slot_free = slot_free;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(DataW-WordW-IndexW){1'b0}}, index_ff, word_ff};
   assign rsp_tuser  = bend_ff;
   assign rsp_tlast  = mend_ff;

endmodule

[hw/rtl/shapad_ctrl.sv]
// Controller of the SHA-256 message padder: sequences byte, padding and
// length steps and counts the words of one transaction. Uses shapad_pkg.
`timescale 1ns / 1ps

module shapad_ctrl
   import shapad_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_HELD  = 3'd1;
   localparam logic [2:0] S_BYTE  = 3'd2;
   localparam logic [2:0] S_MARK  = 3'd3;
   localparam logic [2:0] S_ZERO  = 3'd4;
   localparam logic [2:0] S_LENHI = 3'd5;
   localparam logic [2:0] S_LENLO = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [ResultsW-1:0] nres_ff, nres_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      nres_in       = nres_ff;
      cmd.take_item = 1'b0;
      cmd.op        = OP_NONE;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.take_item = 1'b1;
               nres_in       = '0;
               state_in      = status.held ? S_HELD : S_BYTE;
            end
         end
         S_HELD: begin
            if (status.slot_free) begin
               cmd.op   = OP_HELD;
               nres_in  = nres_ff + 5'd1;
               state_in = S_BYTE;
            end
         end
         S_BYTE: begin
            if (status.slot_free) begin
               cmd.op = OP_BYTE;
               if (status.present && status.word_full) begin
                  nres_in = nres_ff + 5'd1;
               end
               state_in = status.last ? S_MARK : S_IDLE;
            end
         end
         S_MARK, S_ZERO: begin
            if (status.slot_free) begin
               cmd.op   = (state_ff == S_MARK) ? OP_MARK : OP_ZERO;
               nres_in  = nres_ff + 5'd1;
               state_in = status.pre_len ? S_LENHI : S_ZERO;
            end
         end
         S_LENHI: begin
            if (status.slot_free) begin
               cmd.op   = OP_LENHI;
               nres_in  = nres_ff + 5'd1;
               state_in = S_LENLO;
            end
         end
         S_LENLO: begin
            // a transaction returns at most MaxResults words; defer the rest
            if (nres_ff == MaxResults) begin
               cmd.op   = OP_HOLD;
               state_in = S_IDLE;
            end else if (status.slot_free) begin
               cmd.op   = OP_LENLO;
               nres_in  = nres_ff + 5'd1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         nres_ff  <= '0;
      end else begin
         state_ff <= state_in;
         nres_ff  <= nres_in;
      end
   end

endmodule

[hw/rtl/shapad_checker.sv]
// Port-level checks for the SHA-256 message padder, bound to the top level.
// Depends on shapad_pkg and sha256_message_padder.
`timescale 1ns / 1ps

module shapad_checker
   import shapad_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [DataW-1:0] rsp_tdata,
   input logic             rsp_tuser,
   input logic             rsp_tlast
);

   // a stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // block end flag tracks the word index
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == (rsp_tdata[WordW+IndexW-1:WordW] == LastIndex)))
      else $error("block_end does not match word_index");

   // a message always ends on the last word of a block
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("message_end outside a block end");

   // no result right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // hold off input for at least the cycle after each input transaction
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second input transaction taken back to back");

endmodule

bind sha256_message_padder shapad_checker u_shapad_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

[verif/sha256_message_padder_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for sha256_message_padder: streams byte transactions with random
// gaps and backpressure, predicts every padded word and checks results in order.
// Depends on shapad_pkg and the padder RTL.

module sha256_message_padder_tb;
   import shapad_pkg::*;

   localparam int unsigned RandomItems   = 200;
   localparam int unsigned TimeoutCycles = 400000;
   localparam int unsigned SettleCycles  = 80;
   localparam int unsigned LongHold      = 400;
   localparam int unsigned HoldAfter     = 150;  // words seen before the long receiver hold
   localparam int unsigned ReportLimit   = 10;
   localparam logic [PosW-1:0] LengthPos = 6'd56;

   typedef struct {
      logic [ByteW-1:0] data;
      logic             present;
      logic             last;
      int unsigned      gap;
      bit               drain;   // wait until every padded word is out before offering
   } byte_item_type;

   typedef struct packed {
      logic [WordW-1:0]  word;
      logic [IndexW-1:0] index;
      logic              blk_end;
      logic              msg_end;
   } pad_word_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [ByteW-1:0] req_tdata;   // [7:0] data_byte
   logic             req_tuser;   // [0] byte_present
   logic             req_tlast;   // last_of_message
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [DataW-1:0] rsp_tdata;   // [31:0] word_out, [35:32] word_index, [39:36] zero
   logic             rsp_tuser;   // [0] block_end
   logic             rsp_tlast;   // message_end

   byte_item_type  pending_bytes[$];
   pad_word_type   words_due[$];
   byte_item_type  next_byte;
   pad_word_type   due_word;

   // padder state as predicted
   logic [WordW-1:0]  word_acc = '0;
   logic [PosW-1:0]   blk_pos = '0;
   logic [CountW-1:0] byte_count = '0;
   logic              held_valid = 1'b0;
   pad_word_type      held_word = '0;
   int unsigned       words_this_item = 0;

   bit          req_fire = 1'b0;
   bit          rsp_fire = 1'b0;
   bit          hold_done = 1'b0;
   int unsigned cycles = 0;
   int unsigned words_seen = 0;
   int unsigned mismatches = 0;
   int unsigned src_wait = 0;
   int unsigned rx_wait = 0;
   int unsigned hold_left = 0;
   int unsigned counted_items = 0;
   int unsigned directed_items = 0;
   int unsigned msg_len = 0;
   int unsigned pick = 0;

   sha256_message_padder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void emit_word(logic [WordW-1:0] w, logic [IndexW-1:0] idx, logic me);
      pad_word_type pw;
      pw.word    = w;
      pw.index   = idx;
      pw.blk_end = (idx == LastIndex);
      pw.msg_end = me;
      if (words_this_item < MaxResults) begin
         words_due.push_back(pw);
         words_this_item++;
      end else begin
         // no result slot left: the final length word goes out with the next transaction
         held_valid = 1'b1;
         held_word  = pw;
      end
   endfunction

   function automatic void shift_byte(logic [ByteW-1:0] b, logic me);
      word_acc = {word_acc[WordW-ByteW-1:0], b};
      if (blk_pos[1:0] == 2'd3) begin
         emit_word(word_acc, blk_pos[PosW-1:2], me);
         word_acc = '0;
      end
      blk_pos = blk_pos + 6'd1;
   endfunction

   function automatic void pad_predict(logic [ByteW-1:0] data, logic present, logic last);
      logic [63:0] bit_len;
      words_this_item = 0;
      if (held_valid) begin
         held_valid = 1'b0;
         emit_word(held_word.word, held_word.index, held_word.msg_end);
      end
      if (present) begin
         shift_byte(data, 1'b0);
         byte_count = byte_count + 61'd1;
      end
      if (last) begin
         bit_len = {byte_count, 3'b000};
         shift_byte(PadMark, 1'b0);
         while (blk_pos != LengthPos)
            shift_byte('0, 1'b0);
         for (int k = 7; k >= 0; k--)
            shift_byte(bit_len[8*k +: 8], k == 0);
         byte_count = '0;
         blk_pos    = '0;
         word_acc   = '0;
      end
   endfunction

   task automatic add_item(logic [ByteW-1:0] data, logic present, logic last, bit drain);
      byte_item_type it;
      it.data    = data;
      it.present = present;
      it.last    = last;
      it.drain   = drain;
      // every third run of forty transactions goes back to back
      it.gap = ((pending_bytes.size() / 40) % 3 == 2) ? 0 : $urandom_range(0, 9);
      pending_bytes.push_back(it);
      if (present || last)
         counted_items++;
   endtask

   task automatic add_message(int unsigned len, bit last_on_byte, bit drain);
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(0, 19) == 0)
            add_item(ByteW'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
         add_item(ByteW'($urandom_range(0, 255)), 1'b1, last_on_byte && (i == len - 1),
                  drain && (i == 0));
      end
      if (len == 0 || !last_on_byte)
         add_item(ByteW'($urandom_range(0, 255)), 1'b0, 1'b1, drain && (len == 0));
   endtask

   // source: offer the next byte transaction after its gap
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         src_wait = 0;
      end else if (!req_tvalid || req_fire) begin
         if (pending_bytes.size() > 0 && src_wait < pending_bytes[0].gap) begin
            src_wait++;
            req_tvalid <= 1'b0;
         end else if (pending_bytes.size() > 0 &&
                      !(pending_bytes[0].drain && words_due.size() > 0)) begin
            next_byte = pending_bytes.pop_front();
            req_tdata  <= next_byte.data;
            req_tuser  <= next_byte.present;
            req_tlast  <= next_byte.last;
            req_tvalid <= 1'b1;
            src_wait = 0;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // sink: random stall after each word, one long hold to back the block up
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (!hold_done && words_seen >= HoldAfter) begin
            hold_done = 1'b1;
            hold_left = LongHold;
         end
         if (rsp_fire)
            rx_wait = ((cycles / 256) % 4 == 3) ? 0 : $urandom_range(0, 9);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rx_wait > 0) begin
            rx_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // monitor: predict on each byte transaction, check each word transaction
   always @(posedge clock) begin
      req_fire = !reset && req_tvalid && req_tready;
      rsp_fire = !reset && rsp_tvalid && rsp_tready;
      cycles++;
      if (cycles >= TimeoutCycles) begin
         $display("timeout after %0d cycles, %0d words still due", cycles, words_due.size());
         $display("== FAIL ==");
         $finish;
      end else begin
         if (req_fire)
            pad_predict(req_tdata, req_tuser, req_tlast);
         if (rsp_fire) begin
            words_seen++;
            if (words_due.size() == 0) begin
               mismatches++;
               if (mismatches <= ReportLimit)
                  $display("unexpected word: data %h user %b last %b",
                           rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               due_word = words_due.pop_front();
               if (rsp_tdata !== {{(DataW-IndexW-WordW){1'b0}}, due_word.index, due_word.word}
                   || rsp_tuser !== due_word.blk_end || rsp_tlast !== due_word.msg_end) begin
                  mismatches++;
                  if (mismatches <= ReportLimit)
                     $display({"word mismatch: expected word %h index %0d block_end %b ",
                               "msg_end %b, got data %h block_end %b msg_end %b"},
                              due_word.word, due_word.index, due_word.blk_end,
                              due_word.msg_end, rsp_tdata, rsp_tuser, rsp_tlast);
               end
            end
         end
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;

      add_item(8'h00, 1'b0, 1'b1, 1'b0);   // empty message
      add_item(8'hFF, 1'b0, 1'b0, 1'b0);   // no byte, no end: ignored
      add_item(8'hFF, 1'b1, 1'b1, 1'b0);
      add_item(8'h00, 1'b1, 1'b1, 1'b0);
      add_item(8'h61, 1'b1, 1'b0, 1'b1);
      add_item(8'h62, 1'b1, 1'b0, 1'b0);
      add_item(8'h63, 1'b1, 1'b0, 1'b0);
      add_item(8'h00, 1'b0, 1'b1, 1'b0);   // end mark without a byte
      add_item(8'hAA, 1'b1, 1'b0, 1'b0);
      add_item(8'h55, 1'b1, 1'b0, 1'b0);
      add_item(8'h0F, 1'b1, 1'b0, 1'b0);
      add_item(8'hF0, 1'b1, 1'b1, 1'b0);   // end on a word boundary
      add_item(8'hFF, 1'b0, 1'b1, 1'b0);   // empty message, data ignored
      directed_items = counted_items;

      add_message(56, 1'b1, 1'b0);   // last byte is byte 56: length word held over
      add_message(55, 1'b1, 1'b0);
      add_message(64, 1'b0, 1'b1);
      while (counted_items < directed_items + RandomItems) begin
         pick = $urandom_range(0, 99);
         if (pick < 60)
            msg_len = $urandom_range(0, 12);
         else if (pick < 85)
            msg_len = $urandom_range(52, 60);
         else
            msg_len = $urandom_range(61, 70);
         add_message(msg_len, $urandom_range(0, 2) != 0, $urandom_range(0, 19) == 0);
      end
      add_item(8'h00, 1'b0, 1'b0, 1'b0);   // flush a held length word

      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (pending_bytes.size() > 0 || req_tvalid)
         @(posedge clock);
      while (words_due.size() > 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
